// ===== rtl/sfr_pkg.sv =====
// Shared types and constants for the stream find-and-replace block.
// No dependencies; imported by every module under rtl.
`default_nettype none

package sfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int WIN_DEPTH  = 8;
    localparam int WIN_W      = WIN_DEPTH * BYTE_W;
    localparam int CFG_W      = 64;
    localparam int LEN_W      = 4;
    localparam int CNT_W      = 4;
    localparam int ADDR_W     = 5;
    localparam int MAX_RESULTS = 8;

    // register indexes, taken from paddr[4:3]
    localparam logic [1:0] REG_PATTERN_BYTES     = 2'd0;
    localparam logic [1:0] REG_PATTERN_LENGTH    = 2'd1;
    localparam logic [1:0] REG_REPLACEMENT_BYTES = 2'd2;
    localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0] pattern_bytes;
        logic [LEN_W-1:0] pattern_length;
        logic [CFG_W-1:0] replacement_bytes;
        logic [LEN_W-1:0] replacement_length;
    } sfr_cfg_t;

    typedef struct packed {
        logic load;
        logic decide;
        logic emit;
    } sfr_cmd_t;

    typedef struct packed {
        logic done;
        logic last;
    } sfr_status_t;

endpackage

`default_nettype wire

// ===== rtl/stream_find_replace.sv =====
// Top level of the stream find-and-replace block.
// Instantiates sfr_regs, sfr_ctrl and sfr_datapath; depends on sfr_pkg.
//
//   channel   direction  handshake           payload
//   in        sink       in_valid/in_stall    in_byte, in_final
//   out       source     out_valid/out_stall  out_byte, run_last, stream_end
//   config    APB slave  psel/penable/pready  paddr, pwdata, prdata
//
// A request loads the window in ST_IDLE, compares and plans in ST_DECIDE, then
// steps out one result per emit in ST_EMIT; with no results ST_EMIT returns to idle.
// Output stalls stretch the result steps; input is stalled until the last
// result is registered. Reset clears the window fill and all control state.
`default_nettype none

module stream_find_replace
    import sfr_pkg::*;
#(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic              in_final,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [BYTE_W-1:0] out_byte,
    output logic                   run_last,
    output logic                   stream_end,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [CFG_W-1:0]  pwdata,
    output logic      [CFG_W-1:0]  prdata,
    output logic                   pready
);

    sfr_cfg_t    cfg;
    sfr_cmd_t    cmd;
    sfr_status_t status;

    sfr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    sfr_datapath #(
        .PATTERN_MAX (PATTERN_MAX),
        .REPLACE_MAX (REPLACE_MAX)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg        (cfg),
        .in_byte    (in_byte),
        .in_final   (in_final),
        .status     (status),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .stream_end (stream_end)
    );

    // hold off input for the cycle after an accepted request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted on consecutive cycles");

    // mark stream end only on the last result of a request
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stream_end) |-> run_last)
        else $error("stream_end without run_last");

    // raise a result only while a request is in progress
    a_emit_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result raised while idle");

endmodule

`default_nettype wire

// ===== rtl/sfr_regs.sv =====
// Configuration register file with APB-style write and read access.
// Depends on sfr_pkg for register indexes and the configuration struct.
`default_nettype none

module sfr_regs
    import sfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [CFG_W-1:0]  pwdata,
    output logic      [CFG_W-1:0]  prdata,
    output logic                   pready,
    output sfr_cfg_t               cfg
);

    sfr_cfg_t   cfg_reg;
    sfr_cfg_t   cfg_next;
    logic [1:0] reg_index;
    logic       write_en;

    assign reg_index = paddr[ADDR_W-1:3];
    assign write_en  = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            unique case (reg_index)
                REG_PATTERN_BYTES:      cfg_next.pattern_bytes      = pwdata;
                REG_PATTERN_LENGTH:     cfg_next.pattern_length     = pwdata[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  cfg_next.replacement_bytes  = pwdata;
                REG_REPLACEMENT_LENGTH: cfg_next.replacement_length = pwdata[LEN_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_PATTERN_BYTES:      prdata = cfg_reg.pattern_bytes;
            REG_PATTERN_LENGTH:     prdata = CFG_W'(cfg_reg.pattern_length);
            REG_REPLACEMENT_BYTES:  prdata = cfg_reg.replacement_bytes;
            REG_REPLACEMENT_LENGTH: prdata = CFG_W'(cfg_reg.replacement_length);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_bytes      <= '0;
            cfg_reg.pattern_length     <= LEN_W'(1);
            cfg_reg.replacement_bytes  <= '0;
            cfg_reg.replacement_length <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sfr_datapath.sv =====
// Window shift register, match compare, result sequencing and output payload.
// Depends on sfr_pkg; driven by commands from sfr_ctrl.
`default_nettype none

module sfr_datapath
    import sfr_pkg::*;
#(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sfr_cmd_t          cmd,
    input  wire sfr_cfg_t          cfg,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic              in_final,
    output sfr_status_t            status,
    output logic      [BYTE_W-1:0] out_byte,
    output logic                   run_last,
    output logic                   stream_end
);

    logic [WIN_W-1:0]  win_reg,    win_next;
    logic [CNT_W-1:0]  fill_reg,   fill_next;
    logic [CNT_W-1:0]  k_reg,      k_next;
    logic [CNT_W-1:0]  n_reg,      n_next;
    logic [CNT_W-1:0]  na_reg,     na_next;
    logic              match_reg,  match_next;
    logic              fin_reg,    fin_next;
    logic [BYTE_W-1:0] front_reg,  front_next;
    logic [BYTE_W-1:0] byte_reg,   byte_next;
    logic              last_reg,   last_next;
    logic              end_reg,    end_next;

    logic [LEN_W-1:0]     plen;
    logic [LEN_W-1:0]     rlen;
    logic [WIN_DEPTH-1:0] eq;
    logic                 decide_ok;
    logic                 match;
    logic [CNT_W-1:0]     drop;
    logic [CNT_W-1:0]     fill_after;
    logic [CNT_W-1:0]     na;
    logic [CNT_W-1:0]     nb;
    logic [CNT_W:0]       total;
    logic [2:0]           load_pos;
    logic                 is_last;

    always_comb
    begin
        if (cfg.pattern_length == '0)
            plen = LEN_W'(1);
        else if (cfg.pattern_length > LEN_W'(PATTERN_MAX))
            plen = LEN_W'(PATTERN_MAX);
        else
            plen = cfg.pattern_length;

        if (cfg.replacement_length > LEN_W'(REPLACE_MAX))
            rlen = LEN_W'(REPLACE_MAX);
        else
            rlen = cfg.replacement_length;
    end

    always_comb
    begin
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            eq[i] = (LEN_W'(i) >= plen)
                 || (win_reg[BYTE_W*i +: BYTE_W] == cfg.pattern_bytes[BYTE_W*i +: BYTE_W]);
        end
    end

    assign decide_ok  = (fill_reg >= plen);
    assign match      = &eq;
    assign drop       = decide_ok ? (match ? plen : CNT_W'(1)) : '0;
    assign fill_after = fill_reg - drop;
    assign na         = decide_ok ? (match ? rlen : CNT_W'(1)) : '0;
    assign nb         = fin_reg ? fill_after : '0;
    assign total      = {1'b0, na} + {1'b0, nb};
    assign load_pos   = (fill_reg >= CNT_W'(WIN_DEPTH)) ? 3'(WIN_DEPTH - 1) : fill_reg[2:0];
    assign is_last    = (k_reg == n_reg - CNT_W'(1));

    assign status.done = (k_reg == n_reg);
    assign status.last = is_last;

    always_comb
    begin
        win_next   = win_reg;
        fill_next  = fill_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        na_next    = na_reg;
        match_next = match_reg;
        fin_next   = fin_reg;
        front_next = front_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        end_next   = end_reg;

        if (cmd.load)
        begin
            win_next[{load_pos, 3'b000} +: BYTE_W] = in_byte;
            fill_next = CNT_W'(load_pos) + CNT_W'(1);
            fin_next  = in_final;
        end

        if (cmd.decide)
        begin
            front_next = win_reg[BYTE_W-1:0];
            win_next   = win_reg >> {drop, 3'b000};
            fill_next  = fin_reg ? '0 : fill_after;
            match_next = match;
            na_next    = na;
            n_next     = (total > (CNT_W+1)'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS)
                                                           : total[CNT_W-1:0];
            k_next     = '0;
        end

        if (cmd.emit)
        begin
            if (k_reg < na_reg)
            begin
                byte_next = match_reg ? cfg.replacement_bytes[{k_reg[2:0], 3'b000} +: BYTE_W]
                                      : front_reg;
            end
            else
            begin
                // flush: take the oldest byte and advance the window
                byte_next = win_reg[BYTE_W-1:0];
                win_next  = win_reg >> BYTE_W;
            end
            last_next = is_last;
            end_next  = is_last && fin_reg;
            k_next    = k_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            k_reg     <= '0;
            n_reg     <= '0;
            na_reg    <= '0;
            match_reg <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            na_reg    <= na_next;
            match_reg <= match_next;
            fin_reg   <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg   <= win_next;
        front_reg <= front_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        end_reg   <= end_next;
    end

    assign out_byte   = byte_reg;
    assign run_last   = last_reg;
    assign stream_end = end_reg;

endmodule

`default_nettype wire

// ===== rtl/sfr_ctrl.sv =====
// Controller state machine: accept a request, decide, then step out its results.
// Depends on sfr_pkg for the command and status structs.
`default_nettype none

module sfr_ctrl
    import sfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    input  wire sfr_status_t status,
    output sfr_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.done)
                begin
                    state_next = ST_IDLE;
                end
                else if (slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.emit)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for stream_find_replace: directed table, then random streams.
// Depends on sfr_pkg and the RTL under rtl; an internal substitution model predicts output.

module tb
    import sfr_pkg::*;
();

    localparam int QUIET_LIMIT = 1000;
    localparam int N_PHASES    = 10;
    localparam int PHASE_REQS  = 22;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       term;
    } out_rec_t;

    typedef enum logic [1:0] {ROW_REQ, ROW_CHK, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  idx;
        logic [63:0] val;
        logic [7:0]  b;
        logic        fin;
        logic [3:0]  n;
        logic [7:0]  eb;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [BYTE_W-1:0] in_byte;
    logic              in_final;
    logic              out_valid;
    logic              out_stall;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              stream_end;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [CFG_W-1:0]  pwdata;
    logic [CFG_W-1:0]  prdata;
    logic              pready;

    // shadow registers and window of the substitution model
    logic [63:0] pat_bytes;
    logic [3:0]  pat_len;
    logic [63:0] rep_bytes;
    logic [3:0]  rep_len;
    logic [7:0]  win [8];
    int          win_fill;
    out_rec_t    sub_res [8];
    int          sub_cnt;

    out_rec_t    out_due [$];
    out_rec_t    head;
    int          errors;
    int          req_count;
    int          res_count;
    int          streams;
    int          cfg_writes;
    int          quiet_cycles;
    int          stall_left;
    bit          idle_on;
    bit          stall_on;

    dir_row_t dir_rows [32] = '{
        '{ROW_CHK, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b0, 4'd0, 8'h00},
        '{ROW_CHK, REG_PATTERN_BYTES, 64'h0, 8'hff, 1'b1, 4'd1, 8'hff},
        '{ROW_CHK, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b1, 4'd0, 8'h00},
        '{ROW_CFG, REG_PATTERN_BYTES, 64'h0000_0000_0063_6261, 8'h00, 1'b0, 4'd0, 8'h00},
        '{ROW_CFG, REG_PATTERN_LENGTH, 64'd3, 8'h00, 1'b0, 4'd0, 8'h00},
        '{ROW_CFG, REG_REPLACEMENT_BYTES, 64'h5958, 8'h00, 1'b0, 4'd0, 8'h00},
        '{ROW_CFG, REG_REPLACEMENT_LENGTH, 64'd2, 8'h00, 1'b0, 4'd0, 8'h00},
        '{ROW_REQ, REG_PATTERN_BYTES, 64'h0, 8'h61, 1'b0, 4'd0, 8'h00},
        '{ROW_REQ, REG_PATTERN_BYTES, 64'h0, 8'h62, 1'b0, 4'd0, 8'h00},
        '{ROW_REQ, REG_PATTERN_BYTES, 64'h0, 8'h63, 1'b0, 4'd0, 8'h00},
        '{ROW_REQ, REG_PATTERN_BYTES, 64'h0, 8'h7a, 1'b0, 4'd0, 8'h00},
        '{ROW_REQ, REG_PATTERN_BYTES, 64'h0, 8'h61, 1'b0, 4'd0, 8'h00},
        '{ROW_REQ, REG_PATTERN_BYTES, 64'h0, 8'h62, 1'b1, 4'd0, 8'h00},
        '{ROW_CFG, REG_PATTERN_BYTES, 64'hffff_ffff_ffff_ffff, 8'h00, 1'b0, 4'd0, 8'h00},
        '{ROW_CFG, REG_PATTERN_LENGTH, 64'd8, 8'h00, 1'b0, 4'd0, 8'h00},
        '{ROW_CFG, REG_REPLACEMENT_BYTES, 64'h8877_6655_4433_2211, 8'h00, 1'b0, 4'd0, 8'h00},
        '{ROW_CFG, REG_REPLACEMENT_LENGTH, 64'd8, 8'h00, 1'b0, 4'd0, 8'h00},
        '{ROW_REQ, REG_PATTERN_BYTES, 64'h0, 8'hff, 1'b0, 4'd0, 8'h00},
        '{ROW_REQ, REG_PATTERN_BYTES, 64'h0, 8'hff, 1'b0, 4'd0, 8'h00},
        '{ROW_REQ, REG_PATTERN_BYTES, 64'h0, 8'hff, 1'b0, 4'd0, 8'h00},
        '{ROW_REQ, REG_PATTERN_BYTES, 64'h0, 8'hff, 1'b0, 4'd0, 8'h00},
        '{ROW_REQ, REG_PATTERN_BYTES, 64'h0, 8'hff, 1'b0, 4'd0, 8'h00},
        '{ROW_REQ, REG_PATTERN_BYTES, 64'h0, 8'hff, 1'b0, 4'd0, 8'h00},
        '{ROW_REQ, REG_PATTERN_BYTES, 64'h0, 8'hff, 1'b0, 4'd0, 8'h00},
        '{ROW_CFG, REG_PATTERN_LENGTH, 64'd1, 8'h00, 1'b0, 4'd0, 8'h00},
        '{ROW_REQ, REG_PATTERN_BYTES, 64'h0, 8'hff, 1'b1, 4'd0, 8'h00},
        '{ROW_CFG, REG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b0, 4'd0, 8'h00},
        '{ROW_CFG, REG_REPLACEMENT_BYTES, 64'hffff_ffff_ffff_ffff, 8'h00, 1'b0, 4'd0, 8'h00},
        '{ROW_CFG, REG_REPLACEMENT_LENGTH, 64'd12, 8'h00, 1'b0, 4'd0, 8'h00},
        '{ROW_REQ, REG_PATTERN_BYTES, 64'h0, 8'hff, 1'b1, 4'd0, 8'h00},
        '{ROW_CFG, REG_PATTERN_LENGTH, 64'd15, 8'h00, 1'b0, 4'd0, 8'h00},
        '{ROW_REQ, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b1, 4'd0, 8'h00}
    };

    stream_find_replace uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .in_final   (in_final),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .stream_end (stream_end),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 clk = ~clk;

    task automatic report(input string msg);
        errors++;
        if (errors <= 40)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic keep_result(input logic [7:0] b);
        if (sub_cnt < 8)
        begin
            sub_res[sub_cnt] = '{data: b, last: 1'b0, term: 1'b0};
            sub_cnt++;
        end
    endtask

    task automatic shift_window(input int k);
        int i;
        if (k >= win_fill)
            win_fill = 0;
        else
        begin
            for (i = 0; i < win_fill - k; i++)
                win[i] = win[i + k];
            win_fill = win_fill - k;
        end
    endtask

    // substitute one input byte; results land in sub_res[0 .. sub_cnt-1]
    task automatic substitute(input logic [7:0] b, input logic fin);
        int  plen;
        int  rlen;
        int  i;
        bit  hit;
        plen = (pat_len == 4'd0) ? 1 : ((pat_len > 4'd8) ? 8 : int'(pat_len));
        rlen = (rep_len > 4'd8) ? 8 : int'(rep_len);
        sub_cnt = 0;
        if (win_fill >= 8)
            win_fill = 7;
        win[win_fill] = b;
        win_fill++;
        if (win_fill >= plen)
        begin
            hit = 1'b1;
            for (i = 0; i < plen; i++)
                if (win[i] != pat_bytes[8*i +: 8])
                    hit = 1'b0;
            if (hit)
            begin
                for (i = 0; i < rlen; i++)
                    keep_result(rep_bytes[8*i +: 8]);
                shift_window(plen);
            end
            else
            begin
                keep_result(win[0]);
                shift_window(1);
            end
        end
        if (fin)
        begin
            for (i = 0; i < win_fill; i++)
                keep_result(win[i]);
            win_fill = 0;
        end
        if (sub_cnt > 0)
        begin
            sub_res[sub_cnt - 1].last = 1'b1;
            sub_res[sub_cnt - 1].term = fin;
        end
    endtask

    // typed_n < 0: queue what the model predicts; typed_n > 0: queue the typed result; 0: queue nothing
    task automatic push_request(input logic [7:0] b, input logic fin,
                                input int typed_n, input logic [7:0] typed_b);
        int i;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_final <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        substitute(b, fin);
        if (typed_n < 0)
            for (i = 0; i < sub_cnt; i++)
                out_due.push_back(sub_res[i]);
        else if (typed_n > 0)
            out_due.push_back('{data: typed_b, last: 1'b1, term: fin});
        req_count++;
        if (fin)
            streams++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (out_due.size() != 0);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
        drain_results();
        repeat (10) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PATTERN_BYTES:      pat_bytes = val;
            REG_PATTERN_LENGTH:     pat_len   = val[3:0];
            REG_REPLACEMENT_BYTES:  rep_bytes = val;
            REG_REPLACEMENT_LENGTH: rep_len   = val[3:0];
            default: ;
        endcase
        cfg_writes++;
        @(posedge clk);
    endtask

    // random output stall bursts, started only while stall_on is set
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (stall_on && $urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            res_count++;
            if (out_due.size() == 0)
                report($sformatf("unexpected result %02h", out_byte));
            else
            begin
                head = out_due.pop_front();
                if (out_byte !== head.data)
                    report($sformatf("out_byte %02h, want %02h", out_byte, head.data));
                if (run_last !== head.last)
                    report($sformatf("run_last %b, want %b", run_last, head.last));
                if (stream_end !== head.term)
                    report($sformatf("stream_end %b, want %b", stream_end, head.term));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int          r;
        int          ph;
        int          n;
        int          j;
        int          len;
        int          eff;
        int          pick;
        logic [7:0]  alpha [3];
        logic [63:0] pbuf;
        logic [7:0]  bv;
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_byte    = '0;
        in_final   = 1'b0;
        out_stall  = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        stall_left = 0;
        errors     = 0;
        req_count  = 0;
        res_count  = 0;
        streams    = 0;
        cfg_writes = 0;
        pat_bytes  = '0;
        pat_len    = 4'd1;
        rep_bytes  = '0;
        rep_len    = 4'd0;
        win_fill   = 0;
        idle_on    = 1'b1;
        stall_on   = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < 32; r++)
        begin
            case (dir_rows[r].kind)
                ROW_CFG: cfg_write(dir_rows[r].idx, dir_rows[r].val);
                ROW_CHK: push_request(dir_rows[r].b, dir_rows[r].fin,
                                      int'(dir_rows[r].n), dir_rows[r].eb);
                default: push_request(dir_rows[r].b, dir_rows[r].fin, -1, 8'h00);
            endcase
        end

        for (ph = 0; ph < N_PHASES; ph++)
        begin
            idle_on  = (ph < N_PHASES - 2) && ($urandom_range(0, 3) != 0);
            stall_on = (ph < N_PHASES - 2) && ($urandom_range(0, 3) != 0);
            for (j = 0; j < 3; j++)
                alpha[j] = $urandom_range(0, 255);
            for (j = 0; j < 8; j++)
                pbuf[8*j +: 8] = alpha[$urandom_range(0, 2)];
            if ($urandom_range(0, 3) == 0)
                pbuf = {$urandom, $urandom};
            pick = $urandom_range(0, 9);
            if (pick == 0)
                len = 0;
            else if (pick == 1)
                len = $urandom_range(9, 15);
            else
                len = $urandom_range(1, (pick < 6) ? 3 : 8);
            cfg_write(REG_PATTERN_BYTES, pbuf);
            cfg_write(REG_PATTERN_LENGTH, 64'(len));
            cfg_write(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
            cfg_write(REG_REPLACEMENT_LENGTH,
                      64'(($urandom_range(0, 7) == 0) ? $urandom_range(9, 15)
                                                      : $urandom_range(0, 8)));
            eff = (len == 0) ? 1 : ((len > 8) ? 8 : len);
            n = 0;
            while (n < PHASE_REQS)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    len = eff;
                else if (pick < 7)
                    len = $urandom_range(1, eff);
                else
                    len = 1;
                for (j = 0; j < len; j++)
                begin
                    if (pick < 7)
                        bv = pbuf[8*j +: 8];
                    else if (pick < 9)
                        bv = alpha[$urandom_range(0, 2)];
                    else
                        bv = $urandom_range(0, 255);
                    push_request(bv, $urandom_range(0, 15) == 0, -1, 8'h00);
                    n++;
                    if ($urandom_range(0, 60) == 0)
                        drain_results();
                end
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        $display("covered %0d requests in %0d closed streams, %0d register writes",
                 req_count, streams, cfg_writes);
        $display("checked %0d result bytes, %0d mismatches", res_count, errors);
        if (errors == 0 && out_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
